// ----- hdl/sparse_set_insert_remove_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse set assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_INSERT_REMOVE_MACROS_SVH
`define SPARSE_SET_INSERT_REMOVE_MACROS_SVH

// property must hold at every clock edge outside reset
`define SSET_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// condition must never be true outside reset
`define SSET_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ----- hdl/sset_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse set package
// Types and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sset_pkg;

	// fixed field widths of the streams
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned ENT_W    = 32;
	localparam int unsigned M_DATA_W = 24;

	// request kinds
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_ABSENT  = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_MOVE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;   // write one cleared sparse row
		logic accept;  // take the request and issue the reads
		logic commit;  // decide, do first writes, load the result
		logic move;    // write the moved last entry into the hole
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_done;   // clearing pass at last row
		logic out_free;   // result register can take a new result
		logic need_move;  // remove leaves a hole to fill
	} sts_t;

endpackage

// ----- hdl/sparse_set_insert_remove.sv -----
// ----------------------------------------------------------------------------
// Sparse set insert / remove
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Keeps a set of 32-bit entities keyed by their low INDEX_BITS bits, with a
// dense array of up to CAPACITY members and swap-remove. After reset the block
// clears every row of the sparse table (s_tready low), then takes one request
// at a time. A request that moves no member (any failure, any insert, a remove
// of the last member) goes through the registered table reads and then the
// decide and write step before the next accept. A remove that has to move the
// last member into the freed slot also goes through a move step, since the
// single write port of the sparse table must clear one index and rewrite
// another. The decide step also waits while the previous result is still held
// in the result register. One result per request leaves through that
// register, so the next request can be taken while a result waits on m_tready.

module sparse_set_insert_remove
	import sset_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 12,
	parameter int unsigned CAPACITY   = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ENT_W-1:0]    s_tdata,   // [31:0] entity_id
	input  logic                s_tuser,   // [0] action
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [10:0] member_count, [20:11] slot
	output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

	cmd_t cmd;
	sts_t sts;

	sset_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sset_datapath #(
		.INDEX_BITS (INDEX_BITS),
		.CAPACITY   (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- hdl/sset_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sset_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/sset_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sparse set controller
// Sequences the clearing pass and the read, check and move steps of a request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sset_ctrl
	import sset_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.out_free) state_nxt = sts.need_move ? S_MOVE : S_IDLE;
			end
			S_MOVE: begin
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			S_CHECK: begin
				cmd.commit = sts.out_free;
			end
			S_MOVE: begin
				cmd.move = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hdl/sset_datapath.sv -----
// ----------------------------------------------------------------------------
// Sparse set datapath
// Sparse and dense tables, entity count, clear counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sparse_set_insert_remove_macros.svh"

module sset_datapath
	import sset_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 12,
	parameter int unsigned CAPACITY   = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [ENT_W-1:0]    s_tdata,
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0] m_tuser
);

	localparam int unsigned POS_W  = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned SP_W   = POS_W + 1;
	localparam int unsigned SP_DEP = 1 << INDEX_BITS;

	// request registers
	logic                  action_q;
	logic [ENT_W-1:0]      ent_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [CNT_W-1:0]      count_q;
	logic [INDEX_BITS-1:0] clr_q;
	logic [POS_W-1:0]      pos_q;
	logic [ENT_W-1:0]      moved_q;

	// result register
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [SLOT_W-1:0]     out_slot_q;

	// memory ports
	logic                  sp_wr_en;
	logic [INDEX_BITS-1:0] sp_wr_addr;
	logic [SP_W-1:0]       sp_wr_data;
	logic [INDEX_BITS-1:0] sp_rd_addr;
	logic [SP_W-1:0]       sp_rd_data;
	logic                  dn_wr_en;
	logic [POS_W-1:0]      dn_wr_addr;
	logic [ENT_W-1:0]      dn_wr_data;
	logic [POS_W-1:0]      dn_rd_addr;
	logic [ENT_W-1:0]      dn_rd_data;

	// decision signals
	logic                  rd_valid;
	logic [POS_W-1:0]      rd_pos;
	logic [CNT_W-1:0]      cnt_dec;
	logic [POS_W-1:0]      last_pos;
	logic                  ins_ok;
	logic                  rem_ok;
	status_t               status_nxt;
	logic [CNT_W-1:0]      cnt_nxt;
	logic [POS_W-1:0]      slot_nxt;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;
	logic [POS_W+SLOT_W-1:0]  slot_ext;

	sset_ram #(.WIDTH(SP_W), .DEPTH(SP_DEP)) u_sparse (
		.clk     (clk),
		.wr_en   (sp_wr_en),
		.wr_addr (sp_wr_addr),
		.wr_data (sp_wr_data),
		.rd_addr (sp_rd_addr),
		.rd_data (sp_rd_data)
	);

	sset_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_dense (
		.clk     (clk),
		.wr_en   (dn_wr_en),
		.wr_addr (dn_wr_addr),
		.wr_data (dn_wr_data),
		.rd_addr (dn_rd_addr),
		.rd_data (dn_rd_data)
	);

	// read addresses: index from the port at accept, held afterwards
	assign sp_rd_addr = cmd.accept ? s_tdata[INDEX_BITS-1:0] : idx_q;
	assign cnt_dec    = CNT_W'(count_q - CNT_W'(1));
	assign last_pos   = cnt_dec[POS_W-1:0];
	assign dn_rd_addr = last_pos;

	// check step
	assign rd_valid = sp_rd_data[POS_W];
	assign rd_pos   = sp_rd_data[POS_W-1:0];
	assign ins_ok   = (action_q == ACT_INSERT) && !rd_valid &&
	                  (count_q != CNT_W'(CAPACITY));
	assign rem_ok   = (action_q == ACT_REMOVE) && rd_valid && (count_q != '0);

	always_comb begin
		status_nxt = STAT_OK;
		cnt_nxt    = count_q;
		slot_nxt   = '0;
		if (action_q == ACT_INSERT) begin
			if (rd_valid) begin
				status_nxt = STAT_PRESENT;
			end else if (!ins_ok) begin
				status_nxt = STAT_FULL;
			end else begin
				cnt_nxt  = CNT_W'(count_q + CNT_W'(1));
				slot_nxt = count_q[POS_W-1:0];
			end
		end else begin
			if (!rem_ok) begin
				status_nxt = STAT_ABSENT;
			end else begin
				cnt_nxt  = cnt_dec;
				slot_nxt = rd_pos;
			end
		end
	end

	assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_nxt};
	assign slot_ext = {{SLOT_W{1'b0}}, slot_nxt};

	// sparse write port
	always_comb begin
		sp_wr_en   = 1'b0;
		sp_wr_addr = idx_q;
		sp_wr_data = '0;
		priority if (cmd.clear) begin
			sp_wr_en   = 1'b1;
			sp_wr_addr = clr_q;
		end else if (cmd.commit && ins_ok) begin
			sp_wr_en   = 1'b1;
			sp_wr_data = {1'b1, count_q[POS_W-1:0]};
		end else if (cmd.commit && rem_ok) begin
			sp_wr_en   = 1'b1;
		end else if (cmd.move) begin
			sp_wr_en   = 1'b1;
			sp_wr_addr = moved_q[INDEX_BITS-1:0];
			sp_wr_data = {1'b1, pos_q};
		end
	end

	// dense write port
	always_comb begin
		dn_wr_en   = 1'b0;
		dn_wr_addr = pos_q;
		dn_wr_data = moved_q;
		priority if (cmd.commit && ins_ok) begin
			dn_wr_en   = 1'b1;
			dn_wr_addr = count_q[POS_W-1:0];
			dn_wr_data = ent_q;
		end else if (cmd.move) begin
			dn_wr_en   = 1'b1;
		end
	end

	// status to the controller
	assign sts.clr_done  = (clr_q == {INDEX_BITS{1'b1}});
	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.need_move = rem_ok && (rd_pos != last_pos);

	// request capture and hole data
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= s_tuser;
			ent_q    <= s_tdata;
			idx_q    <= s_tdata[INDEX_BITS-1:0];
		end
		if (cmd.commit) begin
			pos_q   <= rd_pos;
			moved_q <= dn_rd_data;
		end
	end

	// entity count and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.commit) count_q <= cnt_nxt;
			if (cmd.clear)  clr_q   <= INDEX_BITS'(clr_q + 1'b1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= status_nxt;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
			out_slot_q   <= slot_ext[SLOT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_DATA_W - COUNT_W - SLOT_W){1'b0}}, out_slot_q, out_count_q};

	// checks
	`SSET_NEVER(a_count_range, count_q > CNT_W'(CAPACITY))
	`SSET_ASSERT(a_commit_loads, cmd.commit |=> out_valid_q)
	`SSET_ASSERT(a_no_overwrite, cmd.commit |-> (!out_valid_q || m_tready))
	`SSET_ASSERT(a_move_after_commit, cmd.move |-> $past(cmd.commit && sts.need_move))

endmodule
